// ===== design/lse_pkg.sv =====
// Shared types, constants and helpers for the LSB stego embed/extract block.
package lse_pkg;

    localparam int PAYLOAD_COUNT_BITS = 24;
    localparam int BITS_DONE_W        = PAYLOAD_COUNT_BITS + 3;
    localparam int BUF_W              = 15;
    localparam int CNT_W              = 4;
    localparam int BYTE_W             = 8;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    localparam logic [CNT_W-1:0] K_MIN = 4'd1;
    localparam logic [CNT_W-1:0] K_MAX = 4'd8;
    localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;
    localparam logic [CNT_W-1:0] PUSH_LIMIT = 4'd7;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_EMBED   = 2'd1,
        CMD_EXTRACT = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_LSB_WIDTH     = 1'b0,
        REG_PAYLOAD_BYTES = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]              lsb_width;
        logic [PAYLOAD_COUNT_BITS-1:0] payload_bytes;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              data_valid;
        logic [1:0]        status;
        logic              last;
    } result_t;

    function automatic logic [15:0] low_mask(input logic [CNT_W-1:0] w);
        low_mask = 16'((17'd1 << w) - 17'd1);
    endfunction

endpackage

// ===== design/lse_if.sv =====
// Valid/ready channel interfaces for the input command and the result beats.
interface lse_req_if
    import lse_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [BYTE_W-1:0] data_in;

    modport source (output valid, output cmd, output data_in, input ready);
    modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface lse_rsp_if
    import lse_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic [1:0]        status;
    logic              last;

    modport source (output valid, output data_out, output data_valid, output status,
                    output last, input ready);
    modport sink   (input valid, input data_out, input data_valid, input status,
                    input last, output ready);
endinterface

// ===== design/lsb_stego_embed_extract.sv =====
// LSB steganography embed/extract top level: input stage, datapath, result register.
// One command beat per clock is accepted into the input register while ready is high; its
// result beat is computed from that register and presented from the result register. A new beat may enter
// every cycle as long as the result side keeps taking beats; while a result waits, the
// input stage holds its beat and ready drops. Throughput is one beat per clock while results
// are taken, as the bit buffer, buffer count and payload bit counter update once per beat. Configuration
// (lsb_width at 0x0, payload_bytes at 0x4) is written over APB by the user only while idle; unchecked by the block.
module lsb_stego_embed_extract
    import lse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    lse_req_if.sink               req,
    lse_rsp_if.source             rsp
);

    cfg_t              cfg;
    result_t           res;
    result_t           res_reg;
    logic              stage_valid_reg;
    logic [1:0]        stage_cmd_reg;
    logic [BYTE_W-1:0] stage_data_reg;
    logic              out_valid_reg;
    logic              advance;

    lse_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (advance),
        .cmd     (stage_cmd_reg),
        .data_in (stage_data_reg),
        .res     (res)
    );

    assign advance   = stage_valid_reg & (~out_valid_reg | rsp.ready);
    assign req.ready = ~stage_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req.ready)
                stage_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready & req.valid)
        begin
            stage_cmd_reg  <= req.cmd;
            stage_data_reg <= req.data_in;
        end
        if (advance)
            res_reg <= res;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.data_out   = res_reg.data_out;
    assign rsp.data_valid = res_reg.data_valid;
    assign rsp.status     = res_reg.status;
    assign rsp.last       = res_reg.last;

endmodule

// ===== design/lse_cfg.sv =====
// APB configuration registers: lsb_width and payload_bytes.
module lse_cfg
    import lse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [CNT_W-1:0]              lsb_width_reg;
    logic [PAYLOAD_COUNT_BITS-1:0] payload_bytes_reg;
    logic                          wr_en;
    reg_idx_t                      idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsb_width_reg     <= K_MIN;
            payload_bytes_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LSB_WIDTH:     lsb_width_reg     <= pwdata[CNT_W-1:0];
                REG_PAYLOAD_BYTES: payload_bytes_reg <= pwdata[PAYLOAD_COUNT_BITS-1:0];
                default:           lsb_width_reg     <= lsb_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LSB_WIDTH:     prdata = APB_DATA_W'(lsb_width_reg);
            REG_PAYLOAD_BYTES: prdata = APB_DATA_W'(payload_bytes_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.lsb_width     = lsb_width_reg;
    assign cfg.payload_bytes = payload_bytes_reg;

endmodule

// ===== design/lse_core.sv =====
// Bit buffer state and the combinational push/embed/extract/restart datapath.
module lse_core
    import lse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              fire,
    input  logic [1:0]        cmd,
    input  logic [BYTE_W-1:0] data_in,
    output result_t           res
);

    logic [BUF_W-1:0]       buf_reg, buf_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [BITS_DONE_W-1:0] done_reg, done_next;

    logic [CNT_W-1:0]       k, n, rest, rest2, cnt2;
    logic [BITS_DONE_W-1:0] total, remaining, done2;
    logic [15:0]            take, xbits, wide, kmask;
    logic [15:0]            rest_mask, rest2_mask;
    logic [BUF_W-1:0]       buf2;
    logic [CNT_W:0]         sum;
    logic [15:0]            out_wide;

    always_comb
    begin
        if (cfg.lsb_width == '0)
            k = K_MIN;
        else if (cfg.lsb_width > K_MAX)
            k = K_MAX;
        else
            k = cfg.lsb_width;

        total     = {cfg.payload_bytes, 3'b000};
        remaining = (done_reg < total) ? (total - done_reg) : '0;
        n         = (remaining < BITS_DONE_W'(k)) ? remaining[CNT_W-1:0] : k;
        kmask     = low_mask(k);

        rest      = cnt_reg - n;
        rest_mask = low_mask(rest);
        take      = ({1'b0, buf_reg} >> rest) & low_mask(n);
        out_wide  = take << (k - n);

        sum        = {1'b0, cnt_reg} + {1'b0, n};
        cnt2       = sum[CNT_W-1:0];
        xbits      = ({8'd0, data_in} >> (k - n)) & low_mask(n);
        wide       = ({1'b0, buf_reg} << n) | xbits;
        buf2       = wide[BUF_W-1:0];
        done2      = done_reg + BITS_DONE_W'(n);
        rest2      = cnt2 - BYTE_BITS;
        rest2_mask = low_mask(rest2);
    end

    always_comb
    begin
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        res.data_out   = '0;
        res.data_valid = 1'b0;
        res.status     = ST_OK;
        res.last       = 1'b0;
        case (cmd_t'(cmd))
            CMD_PUSH:
            begin
                if (cnt_reg > PUSH_LIMIT)
                    res.status = ST_OVERFLOW;
                else
                begin
                    buf_next = BUF_W'({buf_reg, data_in});
                    cnt_next = cnt_reg + BYTE_BITS;
                end
            end
            CMD_EMBED:
            begin
                res.data_valid = 1'b1;
                if (remaining == '0)
                    res.data_out = data_in;
                else if (cnt_reg < n)
                begin
                    res.data_out = data_in;
                    res.status   = ST_UNDERFLOW;
                end
                else
                begin
                    res.data_out = (data_in & ~kmask[BYTE_W-1:0]) | out_wide[BYTE_W-1:0];
                    cnt_next     = rest;
                    buf_next     = buf_reg & rest_mask[BUF_W-1:0];
                    done_next    = done2;
                end
            end
            CMD_EXTRACT:
            begin
                if (remaining != '0)
                begin
                    if (sum > (CNT_W+1)'(BUF_W))
                        res.status = ST_OVERFLOW;
                    else
                    begin
                        done_next = done2;
                        if (cnt2 >= BYTE_BITS)
                        begin
                            res.data_out   = 8'({1'b0, buf2} >> rest2);
                            res.data_valid = 1'b1;
                            res.last       = (done2 == total);
                            cnt_next       = rest2;
                            buf_next       = buf2 & rest2_mask[BUF_W-1:0];
                        end
                        else
                        begin
                            cnt_next = cnt2;
                            buf_next = buf2;
                        end
                    end
                end
            end
            CMD_RESTART:
            begin
                buf_next  = '0;
                cnt_next  = '0;
                done_next = '0;
            end
            default:
            begin
                buf_next = buf_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= '0;
        end
        else if (fire)
        begin
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

endmodule
